>>> rtl/pid_heading_controller_assert.svh
// Assertion macros shared by the heading controller RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef PID_HEADING_CONTROLLER_ASSERT_SVH
`define PID_HEADING_CONTROLLER_ASSERT_SVH

// Condition now implies consequence in the same cycle.
`define PHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phc assertion failed (same cycle)");

// Condition now implies consequence in the next cycle.
`define PHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phc assertion failed (next cycle)");

`endif

>>> rtl/phc_pkg.sv
// Package for the PID heading controller: word types, config set, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package phc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd5;

  localparam logic [15:0] KP_GAIN_RST      = 16'd3840;
  localparam logic [15:0] KI_GAIN_RST      = 16'd0;
  localparam logic [15:0] KD_GAIN_RST      = 16'd205;
  localparam logic [14:0] INTEG_BOUND_RST  = 15'd3200;
  localparam logic [9:0]  OUTPUT_LIMIT_RST = 10'd255;
  localparam logic [15:0] STEP_TIME_RST    = 16'd655;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] kd_gain;
    logic [14:0] integ_bound;
    logic [9:0]  output_limit;
    logic [15:0] step_time;
  } phc_cfg_t;

  typedef struct packed {
    logic               enable;
    logic signed [15:0] target_heading;
    logic signed [15:0] heading;
    logic signed [15:0] yaw_rate;
  } phc_in_t;

  typedef struct packed {
    logic       stopped;
    logic       reverse;
    logic [9:0] drive;
  } phc_out_t;

endpackage

>>> rtl/pid_heading_controller.sv
// PID heading controller with conditional-integration anti-windup. One input
// word is one control tick; it yields one result word. Words pass through an
// input register, combinational arithmetic (three multipliers feeding a single
// add and clamp, a fourth forming the integral step) and an output register:
// a new word is taken every cycle unless out_tready stalls the output register,
// which presents the result word; the integral register updates as a word moves
// from the input to the output register. Configuration writes take effect at
// once and are meant to be made while no word is in flight.
// Depends on phc_pkg, phc_datapath and pid_heading_controller_assert.svh.
`timescale 1ns / 1ps

`include "pid_heading_controller_assert.svh"

module pid_heading_controller
  import phc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // enable[0], target_heading[16:1], heading[32:17], yaw_rate[48:33], zero[55:49]
  input  logic [55:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // stopped[0], reverse[1], drive[11:2], zero[15:12]
  output logic [15:0]          out_tdata
);

  phc_cfg_t           cfg_r;
  logic               s1_valid_r;
  phc_in_t            s1_item_r;
  logic               out_valid_r;
  phc_out_t           out_item_r;
  logic signed [31:0] integral_r;
  logic signed [31:0] integral_nxt;
  phc_out_t           result;
  logic               adv;
  phc_in_t            in_item;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;

  assign in_item.enable         = in_tdata[0];
  assign in_item.target_heading = in_tdata[16:1];
  assign in_item.heading        = in_tdata[32:17];
  assign in_item.yaw_rate       = in_tdata[48:33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain      <= KP_GAIN_RST;
      cfg_r.ki_gain      <= KI_GAIN_RST;
      cfg_r.kd_gain      <= KD_GAIN_RST;
      cfg_r.integ_bound  <= INTEG_BOUND_RST;
      cfg_r.output_limit <= OUTPUT_LIMIT_RST;
      cfg_r.step_time    <= STEP_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN:      cfg_r.kp_gain      <= cfg_wdata;
        REG_KI_GAIN:      cfg_r.ki_gain      <= cfg_wdata;
        REG_KD_GAIN:      cfg_r.kd_gain      <= cfg_wdata;
        REG_INTEG_BOUND:  cfg_r.integ_bound  <= cfg_wdata[14:0];
        REG_OUTPUT_LIMIT: cfg_r.output_limit <= cfg_wdata[9:0];
        REG_STEP_TIME:    cfg_r.step_time    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integral_r  <= 32'sd0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          integral_r <= integral_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (adv && s1_valid_r) begin
      out_item_r <= result;
    end
  end

  phc_datapath u_datapath (
    .cfg          (cfg_r),
    .item         (s1_item_r),
    .integral     (integral_r),
    .result       (result),
    .integral_nxt (integral_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_item_r.drive, out_item_r.reverse, out_item_r.stopped};

  `PHC_ASSERT_NEXT(a_disable_clears, adv && s1_valid_r && !s1_item_r.enable, integral_r == 32'sd0)
  `PHC_ASSERT_NEXT(a_integral_hold, !(adv && s1_valid_r), $stable(integral_r))
  `PHC_ASSERT_NOW(a_stopped_idle, out_valid_r && out_item_r.stopped, out_item_r.drive == 10'd0 && !out_item_r.reverse)
  `PHC_ASSERT_NOW(a_drive_limit, out_valid_r && !out_item_r.stopped, out_item_r.drive <= cfg_r.output_limit)

endmodule

>>> rtl/phc_datapath.sv
// One control step of the heading loop: error, PID sum, clamps, anti-windup.
// Depends on phc_pkg.
`timescale 1ns / 1ps

module phc_datapath
  import phc_pkg::*;
(
  input  phc_cfg_t           cfg,
  input  phc_in_t            item,
  input  logic signed [31:0] integral,
  output phc_out_t           result,
  output logic signed [31:0] integral_nxt
);

  logic signed [16:0] err;
  logic signed [33:0] p_prod;
  logic signed [48:0] i_prod;
  logic signed [32:0] d_prod;
  logic signed [53:0] p_al, i_al, d_al, unsat, lim, neg_lim, outv, mag;
  logic               integrate;
  logic signed [33:0] inc;
  logic signed [34:0] acc, ilim, neg_ilim, acc_c;

  always_comb begin
    err    = $signed({item.target_heading[15], item.target_heading})
           - $signed({item.heading[15], item.heading});
    p_prod = $signed({1'b0, cfg.kp_gain}) * err;
    i_prod = $signed({1'b0, cfg.ki_gain}) * integral;
    d_prod = $signed({1'b0, cfg.kd_gain}) * item.yaw_rate;

    // align all terms to Q.30
    p_al  = {{4{p_prod[33]}}, p_prod, 16'h0000};
    i_al  = {{5{i_prod[48]}}, i_prod};
    d_al  = {{3{d_prod[32]}}, d_prod, 18'h00000};
    unsat = p_al + i_al - d_al;

    lim     = $signed({14'd0, cfg.output_limit, 30'd0});
    neg_lim = -lim;
    outv    = unsat;
    if (unsat > lim) begin
      outv = lim;
    end
    if (outv < neg_lim) begin
      outv = neg_lim;
    end

    integrate = (outv == unsat)
             || ((outv >= lim) && (err < 0))
             || ((outv <= neg_lim) && (err > 0));

    // integral in Q.16
    inc      = err * $signed({1'b0, cfg.step_time});
    acc      = $signed({{3{integral[31]}}, integral}) + $signed({inc[33], inc});
    ilim     = $signed({4'd0, cfg.integ_bound, 16'd0});
    neg_ilim = -ilim;
    acc_c    = acc;
    if (acc > ilim) begin
      acc_c = ilim;
    end
    if (acc_c < neg_ilim) begin
      acc_c = neg_ilim;
    end

    mag = outv[53] ? -outv : outv;

    if (!item.enable) begin
      integral_nxt   = 32'sd0;
      result.stopped = 1'b1;
      result.reverse = 1'b0;
      result.drive   = 10'd0;
    end else begin
      integral_nxt   = integrate ? acc_c[31:0] : integral;
      result.stopped = 1'b0;
      result.reverse = outv[53];
      result.drive   = mag[39:30];
    end
  end

endmodule
